FILE: rtl/mme_pkg.sv
// ----------------------------------------------------------------------------
// mme_pkg: shared types and constants for the matrix multiply engine
// Field widths, request codes, the cell write bus and the token that runs
// down the MAC chain.
// ----------------------------------------------------------------------------
package mme_pkg;

    localparam int MAX_DIM_DEFAULT = 8;
    localparam int MAX_DIM_LIMIT   = 8;

    localparam int MODE_W  = 2;
    localparam int IDX_W   = 3;
    localparam int DIM_W   = 4;
    localparam int VALUE_W = 16;
    localparam int PROD_W  = 2 * VALUE_W;
    localparam int RES_W   = 32;
    // room for MAX_DIM_LIMIT products plus sign
    localparam int SUM_W   = PROD_W + $clog2(MAX_DIM_LIMIT) + 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [MODE_W-1:0] MODE_LOAD_A  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_B  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    // element write broadcast to every cell
    typedef struct packed {
        logic               a_we;
        logic               b_we;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [VALUE_W-1:0] data;
    } wr_t;

    // one result element in flight through the chain
    typedef struct packed {
        logic                    valid;
        logic                    last;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [SUM_W-1:0] sum;
    } token_t;

    // zero acts as one, anything above the limit acts as the limit
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d,
                                                input logic [DIM_W-1:0] dmax);
        logic [DIM_W-1:0] v;
        v = d;
        if (v == '0)
        begin
            v = 4'd1;
        end
        if (v > dmax)
        begin
            v = dmax;
        end
        return v;
    endfunction

endpackage

FILE: rtl/mme_issue.sv
// ----------------------------------------------------------------------------
// mme_issue: result index sequencer
// Walks the result elements in row-major order, one token a cycle, into the
// head of the MAC chain.
// ----------------------------------------------------------------------------
module mme_issue (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           launch,
    input  logic [mme_pkg::DIM_W-1:0]      nr,
    input  logic [mme_pkg::DIM_W-1:0]      nc,
    output logic                           active,
    output mme_pkg::token_t                tok
);

    logic                          active_reg, active_next;
    logic [mme_pkg::IDX_W-1:0]     r_reg, r_next;
    logic [mme_pkg::IDX_W-1:0]     c_reg, c_next;
    logic [mme_pkg::DIM_W-1:0]     nr_reg, nr_next;
    logic [mme_pkg::DIM_W-1:0]     nc_reg, nc_next;
    logic                          row_end;
    logic                          col_end;

    assign col_end = ({1'b0, c_reg} == nc_reg - 4'd1);
    assign row_end = ({1'b0, r_reg} == nr_reg - 4'd1);

    always_comb
    begin
        active_next = active_reg;
        r_next      = r_reg;
        c_next      = c_reg;
        nr_next     = nr_reg;
        nc_next     = nc_reg;
        if (launch)
        begin
            active_next = 1'b1;
            r_next      = '0;
            c_next      = '0;
            nr_next     = nr;
            nc_next     = nc;
        end
        else if (active_reg)
        begin
            if (col_end)
            begin
                c_next = '0;
                r_next = r_reg + 3'd1;
                if (row_end)
                begin
                    active_next = 1'b0;
                end
            end
            else
            begin
                c_next = c_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            r_reg      <= '0;
            c_reg      <= '0;
            nr_reg     <= 4'd1;
            nc_reg     <= 4'd1;
        end
        else
        begin
            active_reg <= active_next;
            r_reg      <= r_next;
            c_reg      <= c_next;
            nr_reg     <= nr_next;
            nc_reg     <= nc_next;
        end
    end

    assign active = active_reg;

    always_comb
    begin
        tok       = '0;
        tok.valid = active_reg;
        tok.last  = row_end && col_end;
        tok.row   = r_reg;
        tok.col   = c_reg;
        tok.sum   = '0;
    end

endmodule

FILE: rtl/mme_cell.sv
// ----------------------------------------------------------------------------
// mme_cell: one multiply-accumulate cell of the chain
// Holds column k of A and row k of B, adds A[r][k]*B[k][c] to the passing
// partial sum and hands the token on.
// ----------------------------------------------------------------------------
module mme_cell #(
    parameter int MAX_DIM  = mme_pkg::MAX_DIM_DEFAULT,
    parameter int CELL_IDX = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mme_pkg::wr_t               wr,
    input  logic [mme_pkg::DIM_W-1:0]  nk,
    input  mme_pkg::token_t            tok_in,
    output mme_pkg::token_t            tok_out
);

    localparam int SEL_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam logic [mme_pkg::IDX_W-1:0] MY_IDX = mme_pkg::IDX_W'(CELL_IDX);
    localparam logic [mme_pkg::DIM_W-1:0] MY_DIM = mme_pkg::DIM_W'(CELL_IDX);

    logic [mme_pkg::VALUE_W-1:0]        a_col_reg [MAX_DIM];
    logic [mme_pkg::VALUE_W-1:0]        b_row_reg [MAX_DIM];
    logic signed [mme_pkg::VALUE_W-1:0] a_sel;
    logic signed [mme_pkg::VALUE_W-1:0] b_sel;
    logic signed [mme_pkg::PROD_W-1:0]  prod;
    logic signed [mme_pkg::SUM_W-1:0]   term;
    mme_pkg::token_t                    tok_reg, tok_next;

    assign a_sel = a_col_reg[tok_in.row[SEL_W-1:0]];
    assign b_sel = b_row_reg[tok_in.col[SEL_W-1:0]];
    assign prod  = a_sel * b_sel;

    always_comb
    begin
        if (MY_DIM < nk)
        begin
            term = {{(mme_pkg::SUM_W - mme_pkg::PROD_W){prod[mme_pkg::PROD_W-1]}}, prod};
        end
        else
        begin
            term = '0;
        end
        tok_next     = tok_in;
        tok_next.sum = tok_in.sum + term;
    end

    // element stores: A entry (row, k) and B entry (k, col)
    always_ff @(posedge clk)
    begin
        if (wr.a_we && (wr.col == MY_IDX))
        begin
            a_col_reg[wr.row[SEL_W-1:0]] <= wr.data;
        end
        if (wr.b_we && (wr.row == MY_IDX))
        begin
            b_row_reg[wr.col[SEL_W-1:0]] <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: rtl/matrix_multiply_engine.sv
// ----------------------------------------------------------------------------
// matrix_multiply_engine: fixed-point general matrix multiply
// Loads Q8.8 elements of A and B, then streams the Q16.16 product in
// row-major order through a chain of MAX_DIM multiply-accumulate cells.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   --------------------   ---------------------------------------
//  request   start & !busy          mode, row, col, value
//  config    cfg_valid & cfg_ready  cfg_index, cfg_data
//  result    result_valid (strobe)  result_value, result_row, result_col, last
//
//  A load request never raises busy.
//  A compute request raises busy: the sequencer issues one element a cycle,
//  each element walks MAX_DIM cells (one per inner index) and is then
//  saturated into the output regs. Results come out one per cycle.
//  cfg_ready is always high.
//  Reset clears control and the dimension registers (to 8); the element
//  stores are not cleared and read as garbage until written.
//  The receiver cannot stall: each result is held for exactly one cycle.
// ----------------------------------------------------------------------------
module matrix_multiply_engine #(
    parameter int MAX_DIM = mme_pkg::MAX_DIM_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                start,
    output logic                                busy,
    input  logic [mme_pkg::MODE_W-1:0]          mode,
    input  logic [mme_pkg::IDX_W-1:0]           row,
    input  logic [mme_pkg::IDX_W-1:0]           col,
    input  logic signed [mme_pkg::VALUE_W-1:0]  value,
    // configuration channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mme_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mme_pkg::DIM_W-1:0]           cfg_data,
    // result channel
    output logic                                result_valid,
    output logic signed [mme_pkg::RES_W-1:0]    result_value,
    output logic [mme_pkg::IDX_W-1:0]           result_row,
    output logic [mme_pkg::IDX_W-1:0]           result_col,
    output logic                                last
);

    localparam logic [mme_pkg::DIM_W-1:0] DIM_MAX = mme_pkg::DIM_W'(MAX_DIM);
    localparam logic [mme_pkg::IDX_W:0]   IDX_MAX = (mme_pkg::IDX_W + 1)'(MAX_DIM);
    localparam int SAT_TOP = mme_pkg::SUM_W - mme_pkg::RES_W + 1;

    // dimension registers
    logic [mme_pkg::DIM_W-1:0] rows_a_reg, inner_dim_reg, cols_b_reg;
    logic [mme_pkg::DIM_W-1:0] nr, nk, nc;

    logic             accept;
    logic             launch;
    logic             in_range;
    logic             issue_active;
    mme_pkg::wr_t     wr;
    mme_pkg::token_t  chain [MAX_DIM+1];
    logic [MAX_DIM:0] chain_valid;

    logic                              result_valid_reg;
    logic signed [mme_pkg::RES_W-1:0]  result_value_reg, result_value_next;
    logic [mme_pkg::IDX_W-1:0]         result_row_reg, result_col_reg;
    logic                              last_reg;
    logic [SAT_TOP-1:0]                sum_top;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= mme_pkg::DIM_RESET;
            inner_dim_reg <= mme_pkg::DIM_RESET;
            cols_b_reg    <= mme_pkg::DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mme_pkg::CFG_ROWS_A:    rows_a_reg    <= cfg_data;
                mme_pkg::CFG_INNER_DIM: inner_dim_reg <= cfg_data;
                mme_pkg::CFG_COLS_B:    cols_b_reg    <= cfg_data;
                default:                ;  // unmapped index, dropped
            endcase
        end
    end

    assign nr = mme_pkg::eff_dim(rows_a_reg, DIM_MAX);
    assign nk = mme_pkg::eff_dim(inner_dim_reg, DIM_MAX);
    assign nc = mme_pkg::eff_dim(cols_b_reg, DIM_MAX);

    // request decode; loads outside the array are dropped
    assign accept   = start && !busy;
    assign in_range = ({1'b0, row} < IDX_MAX) && ({1'b0, col} < IDX_MAX);
    assign launch   = accept && (mode == mme_pkg::MODE_COMPUTE);

    always_comb
    begin
        wr.a_we = accept && in_range && (mode == mme_pkg::MODE_LOAD_A);
        wr.b_we = accept && in_range && (mode == mme_pkg::MODE_LOAD_B);
        wr.row  = row;
        wr.col  = col;
        wr.data = value;
    end

    mme_issue u_issue (
        .clk    (clk),
        .rst_n  (rst_n),
        .launch (launch),
        .nr     (nr),
        .nc     (nc),
        .active (issue_active),
        .tok    (chain[0])
    );

    // cell k adds the k-th inner term; cells at k >= inner_dim pass through
    for (genvar k = 0; k < MAX_DIM; k++)
    begin : g_cell
        mme_cell #(
            .MAX_DIM  (MAX_DIM),
            .CELL_IDX (k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr      (wr),
            .nk      (nk),
            .tok_in  (chain[k]),
            .tok_out (chain[k+1])
        );
    end

    for (genvar k = 0; k <= MAX_DIM; k++)
    begin : g_valid
        assign chain_valid[k] = chain[k].valid;
    end

    // busy until the final element leaves the chain
    assign busy = issue_active || (|chain_valid);

    // saturate to 32 bits: fits when all bits above bit 30 agree
    assign sum_top = chain[MAX_DIM].sum[mme_pkg::SUM_W-1:mme_pkg::RES_W-1];

    always_comb
    begin
        if ((sum_top == '0) || (sum_top == '1))
        begin
            result_value_next = chain[MAX_DIM].sum[mme_pkg::RES_W-1:0];
        end
        else if (chain[MAX_DIM].sum[mme_pkg::SUM_W-1])
        begin
            result_value_next = {1'b1, {(mme_pkg::RES_W-1){1'b0}}};
        end
        else
        begin
            result_value_next = {1'b0, {(mme_pkg::RES_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= chain[MAX_DIM].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_value_reg <= result_value_next;
        result_row_reg   <= chain[MAX_DIM].row;
        result_col_reg   <= chain[MAX_DIM].col;
        last_reg         <= chain[MAX_DIM].last;
    end

    assign result_valid = result_valid_reg;
    assign result_value = result_value_reg;
    assign result_row   = result_row_reg;
    assign result_col   = result_col_reg;
    assign last         = last_reg;

endmodule
